/* rtl/trp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trp_pkg: shared types and constants of the trapezoid rule integrator
// word formats, integrand codes, controller command and status groups,
// cordic constants in q.30
// ----------------------------------------------------------------------------
package trp_pkg;

   localparam int unsigned LimitWidth  = 24;
   localparam int unsigned CountWidth  = 24;
   localparam int unsigned ResultWidth = 64;
   localparam int unsigned ValWidth    = 48;
   localparam int unsigned AngWidth    = 36;
   localparam int unsigned CordicSteps = 30;

   localparam logic [CountWidth-1:0] STEP_COUNT_RESET = 24'd10000000;

   localparam logic [1:0] FUNC_SQUARE = 2'd0;
   localparam logic [1:0] FUNC_CUBE   = 2'd1;
   localparam logic [1:0] FUNC_SINE   = 2'd2;
   localparam logic [1:0] FUNC_NONE   = 2'd3;

   localparam logic signed [AngWidth-1:0] Q30_PI      = 36'sd3373259426;
   localparam logic signed [AngWidth-1:0] Q30_HALF_PI = 36'sd1686629713;
   localparam logic signed [AngWidth-1:0] Q30_TWO_PI  = 36'sd6746518852;
   localparam logic signed [AngWidth-1:0] Q30_GAIN    = 36'sd652032874;

   localparam logic signed [AngWidth-1:0] ATAN_Q30 [CordicSteps] = '{
      36'sd843314857, 36'sd497837829, 36'sd263043837, 36'sd133525159,
      36'sd67021687,  36'sd33543516,  36'sd16775851,  36'sd8388437,
      36'sd4194283,   36'sd2097149,   36'sd1048576,   36'sd524288,
      36'sd262144,    36'sd131072,    36'sd65536,     36'sd32768,
      36'sd16384,     36'sd8192,      36'sd4096,      36'sd2048,
      36'sd1024,      36'sd512,       36'sd256,       36'sd128,
      36'sd64,        36'sd32,        36'sd16,        36'sd8,
      36'sd4,         36'sd2
   };

   typedef struct packed {
      logic signed [LimitWidth-1:0] lower_limit;
      logic signed [LimitWidth-1:0] upper_limit;
      logic [1:0]                   func;
   } req_type;

   typedef struct packed {
      logic signed [ResultWidth-1:0] integral;
      logic                          saturated;
   } rsp_type;

   // which point the integrand unit evaluates
   typedef enum logic [2:0] {
      PT_A = 3'b001,
      PT_B = 3'b010,
      PT_X = 3'b100
   } point_type;

   typedef struct packed {
      logic      load;
      logic      div_step;
      logic      fn_start;
      point_type pt;
      logic      x_step;
      logic      save_fa;
      logic      acc_init;
      logic      acc_add;
      logic      mul_init;
      logic      mul_step;
      logic      out_load;
   } cmd_type;

   typedef struct packed {
      logic sel_bad;
      logic div_last;
      logic fn_done;
      logic rem_zero;
      logic rem_one;
      logic mul_last;
      logic out_free;
   } status_type;

endpackage

/* rtl/trp_fn_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trp_fn_unit: integrand evaluation
// x squared and two x cubed by registered partial products, sine by
// angle reduction and a 30-step iterative cordic; q8.16 in, q.24 out
// ----------------------------------------------------------------------------
module trp_fn_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [1:0]                            sel,
   input  logic signed [trp_pkg::LimitWidth-1:0] point,
   output logic                                  done,
   output logic signed [trp_pkg::ValWidth-1:0]   value
);
   import trp_pkg::*;

   typedef enum logic [6:0] {
      F_IDLE = 7'b0000001,
      F_SQ   = 7'b0000010,
      F_MUL  = 7'b0000100,
      F_SUM  = 7'b0001000,
      F_RED  = 7'b0010000,
      F_FOLD = 7'b0100000,
      F_ROT  = 7'b1000000
   } phase_type;

   phase_type phase_ff, phase_in;
   logic [1:0] sel_ff, sel_in;
   logic signed [LimitWidth-1:0] s_ff, s_in;
   logic signed [47:0] p_ff, p_in;
   logic signed [44:0] lo_ff, lo_in;
   logic signed [43:0] hi_ff, hi_in;
   logic [37:0] mag_ff, mag_in;
   logic neg_ff, neg_in;
   logic [2:0] k_ff, k_in;
   logic signed [AngWidth-1:0] cx_ff, cx_in, cy_ff, cy_in, z_ff, z_in;
   logic [4:0] i_ff, i_in;
   logic done_ff, done_in;
   logic signed [ValWidth-1:0] value_ff, value_in;

   logic signed [39:0] t;
   logic signed [63:0] cube_sum;
   logic signed [37:0] v;
   logic [37:0] sub;
   logic signed [AngWidth-1:0] r0, r1, r2, sx, sy, ang;

   always_comb begin
      t        = p_ff[47:8];
      lo_in    = $signed({1'b0, t[19:0]}) * s_ff;
      hi_in    = $signed({1'b0, t[38:20]}) * s_ff;
      p_in     = s_ff * s_ff;
      cube_sum = (64'(hi_ff) <<< 20) + 64'(lo_ff);
      v        = {point, 14'b0};
      sub      = 38'(Q30_TWO_PI) << k_ff;
      r0       = neg_ff ? -$signed({1'b0, mag_ff[34:0]}) : $signed({1'b0, mag_ff[34:0]});
      if (r0 >= Q30_PI) begin
         r1 = r0 - Q30_TWO_PI;
      end else if (r0 < -Q30_PI) begin
         r1 = r0 + Q30_TWO_PI;
      end else begin
         r1 = r0;
      end
      if (r1 > Q30_HALF_PI) begin
         r2 = Q30_PI - r1;
      end else if (r1 < -Q30_HALF_PI) begin
         r2 = -Q30_PI - r1;
      end else begin
         r2 = r1;
      end
      sx  = cx_ff >>> i_ff;
      sy  = cy_ff >>> i_ff;
      ang = ATAN_Q30[i_ff];
   end

   always_comb begin
      phase_in = phase_ff;
      sel_in   = sel_ff;
      s_in     = s_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      k_in     = k_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      z_in     = z_ff;
      i_in     = i_ff;
      done_in  = 1'b0;
      value_in = value_ff;
      unique case (phase_ff)
         F_IDLE: begin
            if (start) begin
               sel_in = sel;
               s_in   = point;
               neg_in = v[37];
               mag_in = v[37] ? 38'(-v) : 38'(v);
               k_in   = 3'd4;
               phase_in = (sel == FUNC_SINE) ? F_RED : F_SQ;
            end
         end
         F_SQ: phase_in = F_MUL;
         F_MUL: begin
            if (sel_ff == FUNC_SQUARE) begin
               value_in = 48'(t);
               done_in  = 1'b1;
               phase_in = F_IDLE;
            end else begin
               phase_in = F_SUM;
            end
         end
         F_SUM: begin
            value_in = {cube_sum[62:16], 1'b0};
            done_in  = 1'b1;
            phase_in = F_IDLE;
         end
         F_RED: begin
            // one multiple of two pi per cycle, largest first
            if (mag_ff >= sub) begin
               mag_in = mag_ff - sub;
            end
            k_in = k_ff - 3'd1;
            if (k_ff == 3'd0) begin
               phase_in = F_FOLD;
            end
         end
         F_FOLD: begin
            cx_in    = Q30_GAIN;
            cy_in    = '0;
            z_in     = r2;
            i_in     = '0;
            phase_in = F_ROT;
         end
         F_ROT: begin
            if (!z_ff[AngWidth-1]) begin
               cx_in = cx_ff - sy;
               cy_in = cy_ff + sx;
               z_in  = z_ff - ang;
            end else begin
               cx_in = cx_ff + sy;
               cy_in = cy_ff - sx;
               z_in  = z_ff + ang;
            end
            i_in = i_ff + 5'd1;
            if (i_ff == 5'(CordicSteps - 1)) begin
               value_in = 48'(cy_in >>> 6);
               done_in  = 1'b1;
               phase_in = F_IDLE;
            end
         end
         default: phase_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= F_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      sel_ff   <= sel_in;
      s_ff     <= s_in;
      p_ff     <= p_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      k_ff     <= k_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      z_ff     <= z_in;
      i_ff     <= i_in;
      value_ff <= value_in;
   end

   assign done  = done_ff;
   assign value = value_ff;

endmodule

/* rtl/trp_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trp_datapath: divider, sample stepping, accumulator and final scaling
// restoring step divider for h, saturating q.24 accumulator, 16-bit digit
// multiplier for the closing product, result word register
// ----------------------------------------------------------------------------
module trp_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  trp_pkg::cmd_type                      cmd,
   input  trp_pkg::req_type                      req_data,
   input  logic [trp_pkg::CountWidth-1:0]        step_count,
   input  logic                                  rsp_stall,
   output trp_pkg::status_type                   st,
   output logic                                  rsp_valid,
   output trp_pkg::rsp_type                      rsp_data
);
   import trp_pkg::*;

   logic signed [LimitWidth-1:0] a_ff, b_ff;
   logic [1:0] sel_ff;
   logic [CountWidth-1:0] n_ff, cnt_ff, rem_ff, n_in;
   logic dneg_ff;
   logic [48:0] quo_ff;
   logic [5:0] dcnt_ff;
   logic signed [49:0] x_ff, h, x_next;
   logic signed [ValWidth-1:0] fa_ff;
   logic signed [63:0] acc_ff;
   logic flag_ff;
   logic [63:0] ma_ff;
   logic [112:0] prod_ff;
   logic [1:0] mcnt_ff;
   logic neg_ff;
   logic rsp_valid_ff;
   rsp_type rsp_data_ff;

   logic signed [24:0] d;
   logic [24:0] mag, trial, trial_sub;
   logic ge;
   logic fn_done;
   logic signed [ValWidth-1:0] fn_value;
   logic signed [LimitWidth-1:0] point;
   logic signed [48:0] sum49;
   logic signed [64:0] s65;
   logic [64:0] pp;
   logic [8:0] qhi;
   logic [63:0] qlo, limit, res_mag, res;
   logic sat;

   trp_fn_unit u_fn (
      .clock (clock),
      .reset (reset),
      .start (cmd.fn_start),
      .sel   (sel_ff),
      .point (point),
      .done  (fn_done),
      .value (fn_value)
   );

   always_comb begin
      n_in      = (step_count == '0) ? 24'd1 : step_count;
      d         = 25'(req_data.upper_limit) - 25'(req_data.lower_limit);
      mag       = d[24] ? 25'(-d) : 25'(d);
      trial     = {rem_ff, quo_ff[48]};
      ge        = trial >= {1'b0, n_ff};
      trial_sub = trial - {1'b0, n_ff};
      h         = dneg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      x_next    = x_ff + h;
      unique case (cmd.pt)
         PT_A:    point = a_ff;
         PT_B:    point = b_ff;
         PT_X:    point = x_next[47:24];
         default: point = a_ff;
      endcase
      sum49   = 49'(fa_ff) + 49'(fn_value);
      s65     = 65'(acc_ff) + 65'(fn_value);
      pp      = ma_ff[63:48] * quo_ff;
      qhi     = prod_ff[112:104];
      qlo     = prod_ff[103:40];
      limit   = neg_ff ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      sat     = (qhi != '0) || (qlo > limit);
      res_mag = sat ? limit : qlo;
      res     = neg_ff ? -res_mag : res_mag;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_ff    <= req_data.lower_limit;
         b_ff    <= req_data.upper_limit;
         sel_ff  <= req_data.func;
         n_ff    <= n_in;
         cnt_ff  <= n_in - 24'd1;
         dneg_ff <= d[24];
         quo_ff  <= {mag, 24'b0};
         rem_ff  <= '0;
         dcnt_ff <= 6'd48;
         flag_ff <= 1'b0;
      end
      if (cmd.div_step) begin
         rem_ff  <= ge ? trial_sub[23:0] : trial[23:0];
         quo_ff  <= {quo_ff[47:0], ge};
         dcnt_ff <= dcnt_ff - 6'd1;
      end
      if (cmd.save_fa) begin
         fa_ff <= fn_value;
      end
      if (cmd.acc_init) begin
         acc_ff <= 64'(sum49 >>> 1);
         x_ff   <= {{2{a_ff[LimitWidth-1]}}, a_ff, 24'b0};
      end
      if (cmd.x_step) begin
         x_ff <= x_next;
      end
      if (cmd.acc_add) begin
         cnt_ff <= cnt_ff - 24'd1;
         // saturate on signed overflow of the 64-bit sum
         if (s65[64] != s65[63]) begin
            acc_ff  <= s65[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            flag_ff <= 1'b1;
         end else begin
            acc_ff <= s65[63:0];
         end
      end
      if (cmd.mul_init) begin
         ma_ff   <= acc_ff[63] ? 64'(-acc_ff) : 64'(acc_ff);
         neg_ff  <= acc_ff[63] ^ (dneg_ff && (quo_ff != '0));
         prod_ff <= '0;
         mcnt_ff <= '0;
      end
      if (cmd.mul_step) begin
         prod_ff <= (prod_ff << 16) + 113'(pp);
         ma_ff   <= ma_ff << 16;
         mcnt_ff <= mcnt_ff + 2'd1;
      end
      if (cmd.out_load) begin
         if (sel_ff == FUNC_NONE) begin
            rsp_data_ff <= '0;
         end else begin
            rsp_data_ff.integral  <= res;
            rsp_data_ff.saturated <= flag_ff | sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      st.sel_bad  = (sel_ff == FUNC_NONE);
      st.div_last = (dcnt_ff == '0);
      st.fn_done  = fn_done;
      st.rem_zero = (cnt_ff == '0);
      st.rem_one  = (cnt_ff == 24'd1);
      st.mul_last = (mcnt_ff == 2'd3);
      st.out_free = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/trp_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trp_ctrl: sequencing state machine
// steps the datapath through divide, end points, interior samples,
// closing multiply and result hand-off; code 3 goes straight to the hand-off
// ----------------------------------------------------------------------------
module trp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  trp_pkg::status_type st,
   output trp_pkg::cmd_type    cmd
);
   import trp_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_DIV   = 11'b00000000010,
      S_EVA   = 11'b00000000100,
      S_WA    = 11'b00000001000,
      S_EVB   = 11'b00000010000,
      S_WB    = 11'b00000100000,
      S_STEP  = 11'b00001000000,
      S_WS    = 11'b00010000000,
      S_MINIT = 11'b00100000000,
      S_MUL   = 11'b01000000000,
      S_FIN   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.pt   = PT_A;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (st.sel_bad) begin
               state_in = S_FIN;
            end else begin
               cmd.div_step = 1'b1;
               if (st.div_last) begin
                  state_in = S_EVA;
               end
            end
         end
         S_EVA: begin
            cmd.fn_start = 1'b1;
            state_in     = S_WA;
         end
         S_WA: begin
            if (st.fn_done) begin
               cmd.save_fa = 1'b1;
               state_in    = S_EVB;
            end
         end
         S_EVB: begin
            cmd.fn_start = 1'b1;
            cmd.pt       = PT_B;
            state_in     = S_WB;
         end
         S_WB: begin
            if (st.fn_done) begin
               cmd.acc_init = 1'b1;
               state_in     = st.rem_zero ? S_MINIT : S_STEP;
            end
         end
         S_STEP: begin
            cmd.fn_start = 1'b1;
            cmd.pt       = PT_X;
            cmd.x_step   = 1'b1;
            state_in     = S_WS;
         end
         S_WS: begin
            if (st.fn_done) begin
               cmd.acc_add = 1'b1;
               state_in    = st.rem_one ? S_MINIT : S_STEP;
            end
         end
         S_MINIT: begin
            cmd.mul_init = 1'b1;
            state_in     = S_MUL;
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            if (st.mul_last) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (st.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

/* rtl/trapezoid_rule_integrator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trapezoid_rule_integrator_top: fixed-point trapezoid rule integrator
// one request word (limits a, b in q8.16, integrand code) gives one
// response word (q40.24 integral, saturation flag)
// ----------------------------------------------------------------------------
// usage:
//   req_* takes a word when req_valid is high and req_stall low; req_stall
//   is high while an item is in work, the block holds one item at a time.
//   rsp_* presents the result from an output register; it waits there while
//   rsp_stall is high, and the next request is already accepted meanwhile.
//   csr_* writes the step count n (0 counts as 1); always ready, write only
//   while idle. reset sets n to 10000000 and empties the block.
// work per item: the bit-serial divide for h, then both end points and
// n-1 interior samples, each an integrand evaluation (for sine 5 reduction
// steps, one fold and 30 cordic iterations), then the closing multiply and
// the result load; code 3 goes from the divide state straight to the result load.
// a stalled result delays the next one only when that next one is finished too.
// ----------------------------------------------------------------------------
module trapezoid_rule_integrator_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  trp_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output trp_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [trp_pkg::CountWidth-1:0] csr_data
);
   import trp_pkg::*;

   logic [CountWidth-1:0] step_count_ff;
   cmd_type    cmd;
   status_type st;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_count_ff <= STEP_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         step_count_ff <= csr_data;
      end
   end

   assign csr_ready = 1'b1;

   trp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   trp_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_data   (req_data),
      .step_count (step_count_ff),
      .rsp_stall  (rsp_stall),
      .st         (st),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("accepted word did not make the block busy");

   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.out_load))
      else $error("response appeared without a result load");

   a_rsp_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !cmd.out_load) |=> !rsp_valid)
      else $error("taken response word was not dropped");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || !rsp_stall))
      else $error("result load over a waiting response");

endmodule

/* tb/sv/trapezoid_rule_integrator_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trapezoid_rule_integrator_top_tb: self-checking bench of the integrator
// directed and random limit pairs under several step counts; every accepted
// request is predicted in fixed point and compared with the response words
// ----------------------------------------------------------------------------
module trapezoid_rule_integrator_top_tb;
   import trp_pkg::*;

   localparam int  CycleLimit  = 2000000;
   localparam int  DrainCycles = 20;
   localparam longint I64Max   = 64'sh7fffffffffffffff;
   localparam longint I64Min   = 64'sh8000000000000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CountWidth-1:0] csr_data = '0;

   req_type pending_words[$];
   rsp_type integral_queue[$];
   logic [CountWidth-1:0] step_count = STEP_COUNT_RESET;
   int fail_count = 0;
   int cycle_count = 0;
   int req_gap = 0;
   int rsp_gap = 0;
   bit quiet = 1'b0;

   trapezoid_rule_integrator_top dut (.*);

   always #5 clock = ~clock;

   function automatic longint sine_q24(longint s);
      longint r, cx, cy, nx;
      r = (s * 16384) % longint'(Q30_TWO_PI);
      cx = Q30_GAIN;
      cy = 0;
      if (r >= longint'(Q30_PI)) r -= longint'(Q30_TWO_PI);
      if (r < -longint'(Q30_PI)) r += longint'(Q30_TWO_PI);
      if (r > longint'(Q30_HALF_PI)) r = longint'(Q30_PI) - r;
      if (r < -longint'(Q30_HALF_PI)) r = -longint'(Q30_PI) - r;
      for (int i = 0; i < CordicSteps; i++) begin
         if (r >= 0) begin
            nx = cx - (cy >>> i);
            cy = cy + (cx >>> i);
            r -= longint'(ATAN_Q30[i]);
         end else begin
            nx = cx + (cy >>> i);
            cy = cy - (cx >>> i);
            r += longint'(ATAN_Q30[i]);
         end
         cx = nx;
      end
      return cy >>> 6;
   endfunction

   function automatic longint eval_point(logic [1:0] fn, longint s);
      longint t;
      case (fn)
         FUNC_SQUARE: return (s * s) >>> 8;
         FUNC_CUBE: begin
            t = (s * s) >>> 8;
            return 2 * ((t * s) >>> 16);
         end
         default: return sine_q24(s);
      endcase
   endfunction

   function automatic rsp_type integrate(req_type w);
      rsp_type res;
      longint a, b, d, h, x, acc, v;
      longint unsigned n, q, ma, mh;
      logic [127:0] prod, limit;
      bit neg;
      res = '0;
      if (w.func == FUNC_NONE) return res;
      a = w.lower_limit;
      b = w.upper_limit;
      n = (step_count == 0) ? 1 : step_count;
      d = b - a;
      q = ((d < 0) ? -d : d) << 24;
      q = q / n;
      h = (d < 0) ? -longint'(q) : longint'(q);
      acc = (eval_point(w.func, a) + eval_point(w.func, b)) >>> 1;
      x = a * 16777216;
      for (longint unsigned i = 1; i < n; i++) begin
         x += h;
         v = eval_point(w.func, x >>> 24);
         if (v > 0 && acc > I64Max - v) begin
            acc = I64Max;
            res.saturated = 1'b1;
         end else if (v < 0 && acc < I64Min - v) begin
            acc = I64Min;
            res.saturated = 1'b1;
         end else begin
            acc += v;
         end
      end
      neg = (acc < 0) != (h < 0);
      ma = (acc < 0) ? 64'd0 - acc : acc;
      mh = (h < 0) ? 64'd0 - h : h;
      prod = ({64'd0, ma} * {64'd0, mh}) >> 40;
      limit = neg ? (128'd1 << 63) : 128'(I64Max);
      if (prod > limit) begin
         prod = limit;
         res.saturated = 1'b1;
      end
      res.integral = neg ? -prod[63:0] : prod[63:0];
      return res;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) integral_queue.push_back(integrate(req_data));
         if (req_valid && req_stall) begin
            // hold the stalled word
         end else if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            req_gap <= $urandom_range(0, 8);
            req_valid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            req_data <= pending_words.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("trapezoid_rule_integrator_top_tb: FAIL");
         $finish;
      end
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (integral_queue.size() == 0) begin
               $error("unexpected response word integral=%0d", rsp_data.integral);
               fail_count++;
            end else begin
               if (rsp_data.integral !== integral_queue[0].integral) begin
                  $error("integral: expected %0d actual %0d",
                         integral_queue[0].integral, rsp_data.integral);
                  fail_count++;
               end
               if (rsp_data.saturated !== integral_queue[0].saturated) begin
                  $error("saturated: expected %0b actual %0b",
                         integral_queue[0].saturated, rsp_data.saturated);
                  fail_count++;
               end
               void'(integral_queue.pop_front());
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_gap <= $urandom_range(0, 8);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic write_step_count(int v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= 24'(v);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      step_count = 24'(v);
   endtask

   // checked between edges so that the driver's updates have settled
   task automatic drain();
      while (pending_words.size() > 0 || req_valid || integral_queue.size() > 0)
         @(negedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic add_word(int a, int b, logic [1:0] fn);
      req_type w;
      w.lower_limit = 24'(a);
      w.upper_limit = 24'(b);
      w.func = fn;
      pending_words.push_back(w);
   endtask

   task automatic add_random_words(int count);
      int a, b;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 2) == 0) begin
            a = $urandom_range(0, 24'hffffff);
            b = $urandom_range(0, 24'hffffff);
            a = (a << 8) >>> 8;
            b = (b << 8) >>> 8;
         end else begin
            a = $urandom_range(0, 2000000) - 1000000;
            b = a + $urandom_range(0, 600000) - 300000;
         end
         add_word(a, b, (($urandom_range(0, 9) == 0) ? FUNC_NONE :
                         2'($urandom_range(0, 2))));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // single trapezoid: limit extremes, each integrand, reversed and empty interval
      write_step_count(1);
      for (int f = 0; f < 4; f++) begin
         add_word(-8388608, 8388607, 2'(f));
         add_word(8388607, -8388608, 2'(f));
         add_word(65536, 65536, 2'(f));
         add_word(-65536, 131072, 2'(f));
      end
      add_word(8388607, 8388607, FUNC_CUBE);
      add_word(-8388608, -8388608, FUNC_CUBE);
      add_word(0, 205887, FUNC_SINE);
      drain();

      // zero count behaves as one
      write_step_count(0);
      add_word(-300000, 500000, FUNC_SQUARE);
      add_word(100000, -400000, FUNC_SINE);
      drain();

      // largest count, only the zero integrand keeps this short
      write_step_count(24'hffffff);
      add_word(-8388608, 8388607, FUNC_NONE);
      add_word(8388607, 0, FUNC_NONE);
      drain();

      for (int p = 0; p < 5; p++) begin
         write_step_count($urandom_range(1, 48));
         if (p == 4) quiet = 1'b1;
         add_random_words(20);
         drain();
      end

      if (fail_count == 0 && integral_queue.size() == 0) begin
         $display("trapezoid_rule_integrator_top_tb: PASS");
      end else begin
         $display("trapezoid_rule_integrator_top_tb: FAIL");
      end
      $finish;
   end

endmodule
